### design/stable_descending_pair_sort_core_defines.svh
// Assertion macros shared by the checker of the pair sort core
`ifndef STABLE_DESCENDING_PAIR_SORT_CORE_DEFINES_SVH
`define STABLE_DESCENDING_PAIR_SORT_CORE_DEFINES_SVH

// same-cycle implication, sampled on the core clock, off during reset
`define SDPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pair sort core: same-cycle check failed");

// next-cycle implication
`define SDPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pair sort core: next-cycle check failed");

`endif

### design/sdps_pkg.sv
// Types and constants of the stable descending pair sort core
`default_nettype none

package sdps_pkg;

   localparam int KEY_BITS          = 16;
   localparam int SCORE_BITS        = 16;
   localparam int LIST_CAPACITY_DEF = 64;

   typedef struct packed {
      logic [KEY_BITS-1:0]          item_key;
      logic signed [SCORE_BITS-1:0] item_score;
      logic                         last_in;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]          sorted_key;
      logic signed [SCORE_BITS-1:0] sorted_score;
      logic                         last_out;
      logic                         overflow;
   } rsp_type;

   // one slot of the sorted row
   typedef struct packed {
      logic                         valid;
      logic [KEY_BITS-1:0]          key;
      logic signed [SCORE_BITS-1:0] score;
   } entry_type;

   typedef struct packed {
      logic load;   // insert the broadcast pair
      logic drain;  // shift the row one slot towards the head
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

`default_nettype wire

### design/sdps_cell.sv
// One slot of the systolic insertion row
`default_nettype none

module sdps_cell
   import sdps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    new_entry,
   input  wire entry_type    prev_entry,
   input  wire logic         prev_ins,
   input  wire entry_type    next_entry,
   output entry_type         own_entry,
   output logic              own_ins
);

   logic                         valid_ff, valid_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic signed [SCORE_BITS-1:0] score_ff, score_in;

   // strictly greater: an equal score lands behind the ones already held
   assign own_ins = valid_ff && ($signed(new_entry.score) > $signed(score_ff));

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      score_in = score_ff;
      if (ctl.drain) begin
         valid_in = next_entry.valid;
         key_in   = next_entry.key;
         score_in = next_entry.score;
      end else if (ctl.load) begin
         if (prev_ins) begin
            valid_in = prev_entry.valid;
            key_in   = prev_entry.key;
            score_in = prev_entry.score;
         end else if (own_ins || (!valid_ff && prev_entry.valid)) begin
            valid_in = 1'b1;
            key_in   = new_entry.key;
            score_in = new_entry.score;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   assign own_entry.valid = valid_ff;
   assign own_entry.key   = key_ff;
   assign own_entry.score = score_ff;

endmodule

`default_nettype wire

### design/sdps_ctrl.sv
// Load/drain sequencer, overflow tracking and result register
`default_nettype none

module sdps_ctrl
   import sdps_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire logic      last_in,
   input  wire logic      row_full,
   input  wire entry_type head_entry,
   input  wire logic      head_last,
   output logic           busy,
   output cell_ctl_type   ctl,
   output logic           rsp_valid,
   output rsp_type        rsp_data
);

   state_type state_ff, state_in;
   logic      overflow_ff, overflow_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      accept;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;

   always_comb begin
      state_in  = state_ff;
      ctl.load  = 1'b0;
      ctl.drain = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            ctl.load = accept && !row_full;
            if (accept && last_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ctl.drain = 1'b1;
            if (head_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (ctl.drain && head_last) begin
         overflow_in = 1'b0;
      end else if (accept && row_full) begin
         overflow_in = 1'b1;
      end
   end

   assign rsp_valid_in        = ctl.drain;
   assign rsp_in.sorted_key   = head_entry.key;
   assign rsp_in.sorted_score = head_entry.score;
   assign rsp_in.last_out     = head_last;
   assign rsp_in.overflow     = overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### design/stable_descending_pair_sort_core.sv
// Top level of the stable descending pair sort core
`default_nettype none

// Pairs are loaded one per clock while busy is low; each beat is slotted
// into a row of LIST_CAPACITY cells kept in descending score order, equal
// scores staying in arrival order. The beat flagged last_in starts the
// drain: busy rises the next cycle and the row shifts out one pair per
// clock through the result register, the final one flagged last_out. A
// new list may start on the cycle that shows the final result. Results
// cannot be stalled; rsp_valid marks each one for a single cycle. Pairs
// arriving at a full row are dropped and every result of that list shows
// overflow.
module stable_descending_pair_sort_core
   import sdps_pkg::*;
#(
   parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   entry_type    row   [LIST_CAPACITY];
   logic         ins   [LIST_CAPACITY];
   entry_type    new_entry;
   cell_ctl_type ctl;

   assign new_entry.valid = 1'b1;
   assign new_entry.key   = req_data.item_key;
   assign new_entry.score = req_data.item_score;

   for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_ins;

      if (i == 0) begin : g_head
         // the head sees a held, never-displaced neighbour above it
         assign prev_entry = '{valid: 1'b1, key: '0, score: '0};
         assign prev_ins   = 1'b0;
      end else begin : g_body
         assign prev_entry = row[i-1];
         assign prev_ins   = ins[i-1];
      end

      if (i == LIST_CAPACITY - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = row[i+1];
      end

      sdps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_ins   (prev_ins),
         .next_entry (next_entry),
         .own_entry  (row[i]),
         .own_ins    (ins[i])
      );
   end

   sdps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_in    (req_data.last_in),
      .row_full   (row[LIST_CAPACITY-1].valid),
      .head_entry (row[0]),
      .head_last  (!row[1].valid),
      .busy       (busy),
      .ctl        (ctl),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### design/sdps_checker.sv
// Port-level checks of the pair sort core, bound to the top level
`default_nettype none

`include "stable_descending_pair_sort_core_defines.svh"

module sdps_checker
   import sdps_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // a last beat always starts a drain
   `SDPS_ASSERT_NEXT(a_last_starts_drain, start && !busy && req_data.last_in, busy)

   // no new list while a run is still going out
   `SDPS_ASSERT_NOW(a_busy_mid_run, rsp_valid && !rsp_data.last_out, busy)

   // a run is one unbroken burst
   `SDPS_ASSERT_NEXT(a_run_contiguous, rsp_valid && !rsp_data.last_out, rsp_valid)

   // scores never rise within a run
   `SDPS_ASSERT_NEXT(a_run_descending, rsp_valid && !rsp_data.last_out,
      $signed(rsp_data.sorted_score) <= $signed($past(rsp_data.sorted_score)))

endmodule

bind stable_descending_pair_sort_core sdps_checker u_sdps_checker (.*);

`default_nettype wire

### sim/tb.sv
// Testbench for the stable descending pair sort core: directed lists, then random lists
module tb;
   import sdps_pkg::*;

   localparam int RANDOM_BEATS = 500;

   typedef struct packed {
      req_type beat;
      logic    typed;   // expectation typed in below rather than predicted
      rsp_type want;
   } stim_row_type;

   // single-pair lists at the extremes carry their result; the rest go to the predictor
   localparam stim_row_type DIRECTED [20] = '{
      '{'{16'hFFFF, 16'sh7FFF, 1'b1}, 1'b1, '{16'hFFFF, 16'sh7FFF, 1'b1, 1'b0}},
      '{'{16'h0000, 16'sh8001, 1'b1}, 1'b1, '{16'h0000, 16'sh8001, 1'b1, 1'b0}},
      '{'{16'h5A5A, 16'sh8000, 1'b1}, 1'b1, '{16'h5A5A, 16'sh8000, 1'b1, 1'b0}},
      '{'{16'hA5A5, 16'sh0000, 1'b1}, 1'b1, '{16'hA5A5, 16'sh0000, 1'b1, 1'b0}},
      // equal scores interleaved with others: arrival order must hold
      '{'{16'h0001, 16'sh0005, 1'b0}, 1'b0, '0},
      '{'{16'h0002, 16'shFFFD, 1'b0}, 1'b0, '0},
      '{'{16'h0003, 16'sh0005, 1'b0}, 1'b0, '0},
      '{'{16'h0004, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'h0005, 16'sh0005, 1'b1}, 1'b0, '0},
      // ascending arrival, every beat moves to the head
      '{'{16'h0010, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'h0011, 16'shFFFF, 1'b0}, 1'b0, '0},
      '{'{16'h0012, 16'sh0000, 1'b0}, 1'b0, '0},
      '{'{16'h0013, 16'sh0001, 1'b0}, 1'b0, '0},
      '{'{16'h0014, 16'sh7FFF, 1'b1}, 1'b0, '0},
      // a list all at the sentinel score, then one of two pairs
      '{'{16'h0020, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'h0021, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'h0022, 16'sh8000, 1'b0}, 1'b0, '0},
      '{'{16'h0023, 16'sh8000, 1'b1}, 1'b0, '0},
      '{'{16'hFFFF, 16'sh0100, 1'b0}, 1'b0, '0},
      '{'{16'h0000, 16'sh00FF, 1'b1}, 1'b0, '0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic    typed_now = 1'b0;
   rsp_type typed_want = '0;

   // predictor copy of the sorted row
   logic [KEY_BITS-1:0]          row_key   [LIST_CAPACITY_DEF];
   logic signed [SCORE_BITS-1:0] row_score [LIST_CAPACITY_DEF];
   int                           row_fill = 0;
   logic                         row_dropped = 1'b0;
   rsp_type                      sorted_q [$];
   int                           errors = 0;

   stable_descending_pair_sort_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   // slot an accepted beat into the row; a last beat releases the whole row
   task automatic take_pair(input req_type beat);
      int pos;
      rsp_type res;
      if (row_fill < LIST_CAPACITY_DEF) begin
         pos = row_fill;
         while (pos > 0 && $signed(row_score[pos-1]) < $signed(beat.item_score)) begin
            row_key[pos] = row_key[pos-1];
            row_score[pos] = row_score[pos-1];
            pos--;
         end
         row_key[pos] = beat.item_key;
         row_score[pos] = beat.item_score;
         row_fill++;
      end else begin
         row_dropped = 1'b1;
      end
      if (beat.last_in) begin
         if (typed_now) begin
            sorted_q.push_back(typed_want);
         end else begin
            for (int k = 0; k < row_fill; k++) begin
               res.sorted_key = row_key[k];
               res.sorted_score = row_score[k];
               res.last_out = (k == row_fill - 1);
               res.overflow = row_dropped;
               sorted_q.push_back(res);
            end
         end
         row_fill = 0;
         row_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (sorted_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none got %h", $time, rsp_data);
         end else begin
            want = sorted_q.pop_front();
            note_field("sorted_key", want.sorted_key, rsp_data.sorted_key);
            note_field("sorted_score", want.sorted_score, rsp_data.sorted_score);
            note_field("last_out", 16'(want.last_out), 16'(rsp_data.last_out));
            note_field("overflow", 16'(want.overflow), 16'(rsp_data.overflow));
         end
      end
      // check before predicting: a new list may open on the final result's cycle
      if (!reset && start && !busy)
         take_pair(req_data);
   end

   // present a beat and hold it until the core takes it
   task automatic send_pair(input req_type beat, input logic typed, input rsp_type want);
      start <= 1'b1;
      req_data <= beat;
      typed_now <= typed;
      typed_want <= want;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_maybe(input bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // the next edge comes after the predictor has taken the final beat
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sorted_q.size() != 0);
   endtask

   function automatic req_type rand_pair(input logic last);
      req_type p;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      p.item_key = 16'($urandom);
      if (pick < 5)
         p.item_score = 16'($urandom_range(0, 6)) - 16'd3;   // many ties
      else if (pick < 7)
         p.item_score = 16'($urandom);
      else if (pick == 7)
         p.item_score = 16'sh7FFF;
      else if (pick == 8)
         p.item_score = $urandom_range(0, 1) ? 16'sh8000 : 16'sh8001;
      else
         p.item_score = '0;
      p.last_in = last;
      return p;
   endfunction

   initial begin : stimulus
      int sent;
      int lists;
      int len;
      int unsigned pick;
      sent = 0;
      lists = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_pair(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
         idle_maybe(1'b1);
      end
      wait_drained();

      while (sent < RANDOM_BEATS) begin
         // first lists sit at, just past and well past capacity
         if (lists == 0)
            len = LIST_CAPACITY_DEF;
         else if (lists == 1)
            len = LIST_CAPACITY_DEF + 1;
         else if (lists == 2)
            len = LIST_CAPACITY_DEF + 6;
         else begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               len = $urandom_range(1, 6);
            else if (pick < 90)
               len = $urandom_range(7, 30);
            else
               len = $urandom_range(60, 70);
         end
         for (int j = 0; j < len; j++) begin
            send_pair(rand_pair(j == len - 1), 1'b0, '0);
            sent++;
            // a quiet run of beats with the sender never pausing
            idle_maybe(sent < 250 || sent >= 350);
         end
         lists++;
         if (lists == 12)
            wait_drained();
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (sorted_q.size() != 0) begin
         errors++;
         $display("%0t: results missing, expected %0d more got 0", $time, sorted_q.size());
      end
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
